FILE: src/itda_pkg.sv
// Shared constants for the integer to decimal ASCII unit.
package itda_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = 10;
  localparam int unsigned CntW    = $clog2(ValueW);
  localparam int unsigned IdxW    = $clog2(NumDig);

  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

endpackage

FILE: src/itda_if.sv
// Request channels of the integer to decimal ASCII unit.
interface itda_in_if import itda_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if import itda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: src/int_to_decimal_ascii_unit.sv
// Top level: signed 32-bit integer to decimal ASCII characters.
//
//   channel | dir | payload               | handshake
//   in_i    | in  | value (s32)           | valid/ready, one request per number
//   out_o   | out | character (u8), last  | valid/ready, one request per character
//
// A number is accepted, converted by shift-and-add-3 on the BCD digit registers,
// its leading digit is found, and then 1 to 11 characters are emitted.
// in_i.ready is high only between numbers; the final character may still wait
// in the output register while the next number is accepted.
// A stalled out_o holds the output register and freezes the character sequence.
// Reset clears the sequencer and the output register.
module int_to_decimal_ascii_unit import itda_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  itda_in_if.sink  in_i,
  itda_out_if.source out_o
);

  typedef enum logic [1:0] {StIdle, StConv, StFind, StEmit} state_e;

  state_e              state_q, state_d;
  logic [ValueW-1:0]   mag_q, mag_d;
  logic [DigitW-1:0]   bcd_q [NumDig];
  logic [DigitW-1:0]   bcd_d [NumDig];
  logic [DigitW-1:0]   corr  [NumDig];
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     first_nz;
  logic                neg_q, neg_d;
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    char_q, char_d;
  logic                last_q, last_d;
  logic [ValueW-1:0]   raw;

  assign raw        = in_i.value;
  assign in_i.ready = (state_q == StIdle);

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      corr[i] = (bcd_q[i] >= DabbleLimit) ? bcd_q[i] + DabbleAdd : bcd_q[i];
    end
    first_nz = '0;
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i] != '0) begin
        first_nz = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          neg_d = raw[ValueW-1];
          mag_d = raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
          for (int i = 0; i < NumDig; i++) begin
            bcd_d[i] = '0;
          end
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        mag_d    = {mag_q[ValueW-2:0], 1'b0};
        bcd_d[0] = {corr[0][DigitW-2:0], mag_q[ValueW-1]};
        for (int i = 1; i < NumDig; i++) begin
          bcd_d[i] = {corr[i][DigitW-2:0], corr[i-1][DigitW-1]};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ValueW - 1)) begin
          state_d = StFind;
        end
      end
      StFind: begin
        idx_d   = first_nz;
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = CharZero + {{(CharW-DigitW){1'b0}}, bcd_q[idx_q]};
            last_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - IdxW'(1);
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      for (int i = 0; i < NumDig; i++) begin
        bcd_q[i] <= '0;
      end
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      bcd_q       <= bcd_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

endmodule

FILE: src/itda_checker.sv
// Port-level checks for the integer to decimal ASCII unit, bound to the top level.
module itda_checker import itda_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] out_character_i,
  input logic             out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_character_i) && $stable(out_last_i))
    else $error("stalled output request changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while conversion in flight");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_character_i == CharMinus ||
      (out_character_i >= CharZero && out_character_i <= CharNine))
    else $error("illegal output character");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_character_i == CharMinus |-> !out_last_i)
    else $error("minus sign flagged last");

endmodule

bind int_to_decimal_ascii_unit itda_checker u_itda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_last_i      (out_o.last)
);

FILE: tb/int_to_decimal_ascii_unit_tb.sv
// Testbench for int_to_decimal_ascii_unit: random and edge-case numbers, checked per character.
module int_to_decimal_ascii_unit_tb import itda_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomNums = 500;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned Radix      = 10;

  typedef struct {
    logic signed [ValueW-1:0] value;
    int unsigned              gap;
    bit                       drain;
  } num_req_t;

  typedef struct {
    logic [CharW-1:0] character;
    logic             last;
  } text_char_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                     in_valid  = 1'b0;
  logic signed [ValueW-1:0] in_value  = '0;
  logic                     out_ready = 1'b0;

  itda_in_if  in_if ();
  itda_out_if out_if ();

  assign in_if.valid  = in_valid;
  assign in_if.value  = in_value;
  assign out_if.ready = out_ready;

  int_to_decimal_ascii_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  num_req_t    pending_q[$];
  text_char_t  text_q[$];
  num_req_t    next_req;
  text_char_t  seen_char;
  text_char_t  want_char;
  logic        in_took;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned nums_taken;
  int unsigned negs_taken;
  int unsigned chars_seen;
  int unsigned longest_text;
  int unsigned drains_done;
  bit          quiet;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Expand one number into its expected decimal characters.
  function automatic void queue_decimal(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] dig [NumDig];
    text_char_t        c;
    int                n;
    mag = v[ValueW-1] ? (~v + 1'b1) : v;
    n   = 0;
    do begin
      dig[n] = DigitW'(mag % Radix);
      mag    = mag / Radix;
      n++;
    end while (mag != 0 && n < NumDig);
    if (v[ValueW-1]) begin
      c.character = CharMinus;
      c.last      = 1'b0;
      text_q.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.character = CharZero + CharW'(dig[i]);
      c.last      = (i == 0);
      text_q.push_back(c);
    end
    if (n + int'(v[ValueW-1]) > longest_text) longest_text = n + int'(v[ValueW-1]);
  endfunction

  // Request driver: present the next number, hold it until taken.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_value <= '0;
      gap_left <= 0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0 && pending_q[0].drain) begin
        in_valid <= 1'b0;
        if (text_q.size() == 0) begin
          void'(pending_q.pop_front());
          drains_done++;
        end
      end else if (pending_q.size() != 0) begin
        next_req = pending_q.pop_front();
        in_valid <= 1'b1;
        in_value <= next_req.value;
        gap_left <= next_req.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  assign quiet = nums_taken >= 200 && nums_taken < 300;

  // Character sink: ready with random stalls.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left <= pick_gap();
    end
  end

  // Monitor: predict on accepted numbers, compare accepted characters.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        queue_decimal(in_if.value);
        nums_taken++;
        if (in_if.value < 0) negs_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        chars_seen++;
        seen_char.character = out_if.character;
        seen_char.last      = out_if.last;
        if (text_q.size() == 0) begin
          note_mismatch($sformatf("unexpected char 0x%02h last=%b",
                                  seen_char.character, seen_char.last));
        end else begin
          want_char = text_q.pop_front();
          if (want_char.character !== seen_char.character || want_char.last !== seen_char.last)
            note_mismatch($sformatf("char exp 0x%02h last=%b, got 0x%02h last=%b",
                                    want_char.character, want_char.last,
                                    seen_char.character, seen_char.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timeout: no request moved for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ValueW-1:0] directed [] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009, 32'h0000_000A,
      32'hFFFF_FFF6, 32'h0000_0063, 32'h0000_0064, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0001, 32'h3B9A_C9FF, 32'h3B9A_CA00, 32'hC465_3601, 32'hC465_3600,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h075B_CD15, 32'hF8A4_32EB, 32'h7735_93FF,
      32'h0001_869F, 32'hFFFE_7961
    };
    num_req_t          r;
    int unsigned       ndig;
    longint unsigned   lo;
    longint unsigned   hi;

    idle_cycles  = 0;
    mismatches   = 0;
    nums_taken   = 0;
    negs_taken   = 0;
    chars_seen   = 0;
    longest_text = 0;
    drains_done  = 0;

    foreach (directed[i]) begin
      r.value = directed[i];
      r.gap   = pick_gap();
      r.drain = 1'b0;
      pending_q.push_back(r);
    end
    r.drain = 1'b1;
    r.gap   = 0;
    pending_q.push_back(r);

    for (int i = 0; i < RandomNums; i++) begin
      r.drain = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        r.value = $urandom;
      end else begin
        ndig = $urandom_range(1, NumDig);
        lo   = 1;
        repeat (ndig - 1) lo = lo * Radix;
        hi   = lo * Radix - 1;
        if (ndig == 1) lo = 0;
        if (hi > 32'h7FFF_FFFF) hi = 32'h7FFF_FFFF;
        r.value = $urandom_range(int'(hi), int'(lo));
        if ($urandom_range(0, 1) == 1) r.value = -r.value;
      end
      r.gap = (i >= 180 && i < 280) ? 0 : pick_gap();
      pending_q.push_back(r);
      if (i == RandomNums / 2) begin
        r.drain = 1'b1;
        r.gap   = 0;
        pending_q.push_back(r);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || in_valid || text_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (text_q.size() != 0) note_mismatch($sformatf("%0d chars never arrived", text_q.size()));

    $display("converted %0d numbers (%0d negative) into %0d characters, longest text %0d",
             nums_taken, negs_taken, chars_seen, longest_text);
    $display("including both 32-bit extremes, zero, %0d full drains and random stalls",
             drains_done);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
